// ===== sv/irot_pkg.sv =====
// Shared constants, codes and types for the image rotate inverse map block.
// No dependencies; every other file of the block but irot_ram imports this package.

package irot_pkg;

  localparam int MAX_ROWS  = 256;
  localparam int MAX_COLS  = 256;
  localparam int MEM_DEPTH = MAX_ROWS * MAX_COLS;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);

  localparam int FRAC_W    = 14;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int ROWS_W    = 9;
  localparam int ANG_W     = 16;
  localparam int CH_W      = 8;
  localparam int PIX_W     = 3 * CH_W;
  localparam int DIM_W     = 10;
  localparam int DIM_SAT   = 1023;

  // Corner products, box bounds, mapped points, back-map products and sums.
  localparam int PROD_W  = ROWS_W + 1 + ANG_W;
  localparam int BOX_W   = PROD_W + 2;
  localparam int PT_W    = BOX_W;
  localparam int MUL_W   = PT_W + ANG_W;
  localparam int SUM_W   = MUL_W + 2;
  localparam int COORD_W = SUM_W - 2 * FRAC_W;

  localparam int SETTLE = 3;
  localparam int CNT_W  = $clog2(SETTLE + 1);

  localparam logic [CH_W-1:0]   WHITE      = CH_W'(255);
  localparam logic [ADDR_W-1:0] COL_STRIDE = ADDR_W'(MAX_COLS);

  localparam logic [ROWS_W-1:0]       ROWS_RST = ROWS_W'(256);
  localparam logic [ROWS_W-1:0]       COLS_RST = ROWS_W'(256);
  localparam logic signed [ANG_W-1:0] COS_RST  = ANG_W'(16384);
  localparam logic signed [ANG_W-1:0] SIN_RST  = ANG_W'(0);

  typedef enum logic [0:0] {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } irot_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ROWS = 2'd0,
    CFG_COLS = 2'd1,
    CFG_COS  = 2'd2,
    CFG_SIN  = 2'd3
  } irot_cfg_e;

  typedef struct packed {
    logic signed [ANG_W-1:0] cos_v;
    logic signed [ANG_W-1:0] sin_v;
    logic [ROWS_W-1:0]       rows;
    logic [ROWS_W-1:0]       cols;
    logic signed [BOX_W-1:0] rmin;
    logic signed [BOX_W-1:0] cmin;
    logic [DIM_W-1:0]        out_rows;
    logic [DIM_W-1:0]        out_cols;
    logic                    busy;
  } irot_geom_t;

  typedef struct packed {
    logic              rd;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [PIX_W-1:0]  wdata;
  } irot_ctl_t;

  typedef struct packed {
    logic              rd;
    logic              we;
    logic              in_src;
    logic [ADDR_W-1:0] addr;
    logic [PIX_W-1:0]  wdata;
  } irot_mreq_t;

endpackage

// ===== sv/irot_if.sv =====
// Request and result channel interfaces of the image rotate inverse map block.
// Depends on irot_pkg for field widths and the operation code type.

interface irot_in_if import irot_pkg::*; ();
  logic              valid;
  logic              ready;
  irot_op_e          operation;
  logic [ROWS_W-1:0] row;
  logic [ROWS_W-1:0] col;
  logic [CH_W-1:0]   red_in;
  logic [CH_W-1:0]   green_in;
  logic [CH_W-1:0]   blue_in;

  modport source (output valid, operation, row, col, red_in, green_in, blue_in,
                  input ready);
  modport sink (input valid, operation, row, col, red_in, green_in, blue_in,
                output ready);
endinterface

interface irot_out_if import irot_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CH_W-1:0]  red_out;
  logic [CH_W-1:0]  green_out;
  logic [CH_W-1:0]  blue_out;
  logic             inside_res;
  logic [DIM_W-1:0] out_rows;
  logic [DIM_W-1:0] out_cols;

  modport source (output valid, red_out, green_out, blue_out, inside_res, out_rows,
                  out_cols, input ready);
  modport sink (input valid, red_out, green_out, blue_out, inside_res, out_rows,
                out_cols, output ready);
endinterface

// ===== sv/irot_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.

module irot_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/irot_box.sv =====
// Configuration registers and the derived bounding box of the rotated image.
// Depends on irot_pkg; results reach the mapping pipeline as irot_geom_t.

module irot_box import irot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output irot_geom_t           geom_o
);

  logic [ROWS_W-1:0]        rows_q, cols_q;
  logic signed [ANG_W-1:0]  cos_q, sin_q;
  logic [CNT_W-1:0]         cnt_q, cnt_d;

  logic signed [ROWS_W:0]   rm1, cm1;
  logic signed [PROD_W-1:0] a_d, b_d, c_d, d_d;
  logic signed [PROD_W-1:0] a_q, b_q, c_q, d_q;

  logic signed [BOX_W-1:0]  ax, bx, cx, dx, ndx;
  logic signed [BOX_W-1:0]  rmin_d, cmin_d, rmin_q, cmin_q;
  logic [BOX_W-1:0]         rspan_d, cspan_d, rspan_q, cspan_q;
  logic [BOX_W-1:0]         rceil, cceil;
  logic [DIM_W-1:0]         orows_d, ocols_d, orows_q, ocols_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
      cos_q  <= COS_RST;
      sin_q  <= SIN_RST;
    end else if (cfg_we_i) begin
      case (irot_cfg_e'(cfg_idx_i))
        CFG_ROWS: rows_q <= cfg_data_i[ROWS_W-1:0];
        CFG_COLS: cols_q <= cfg_data_i[ROWS_W-1:0];
        CFG_COS:  cos_q  <= $signed(cfg_data_i[ANG_W-1:0]);
        CFG_SIN:  sin_q  <= $signed(cfg_data_i[ANG_W-1:0]);
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cfg_we_i) begin
      cnt_d = CNT_W'(SETTLE);
    end else if (cnt_q != '0) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= CNT_W'(SETTLE);
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // Last corner indexes and the four corner products.
  assign rm1 = $signed({1'b0, rows_q}) - (ROWS_W + 1)'(1);
  assign cm1 = $signed({1'b0, cols_q}) - (ROWS_W + 1)'(1);
  assign a_d = rm1 * cos_q;
  assign b_d = cm1 * sin_q;
  assign c_d = cm1 * cos_q;
  assign d_d = rm1 * sin_q;

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    c_q <= c_d;
    d_q <= d_d;
  end

  // Box with bounds starting at zero: per-term minimum and absolute value.
  assign ax  = BOX_W'(a_q);
  assign bx  = BOX_W'(b_q);
  assign cx  = BOX_W'(c_q);
  assign dx  = BOX_W'(d_q);
  assign ndx = -dx;

  always_comb begin
    rmin_d  = (ax[BOX_W-1] ? ax : '0) + (bx[BOX_W-1] ? bx : '0);
    cmin_d  = (cx[BOX_W-1] ? cx : '0) + (ndx[BOX_W-1] ? ndx : '0);
    rspan_d = (ax[BOX_W-1] ? -ax : ax) + (bx[BOX_W-1] ? -bx : bx);
    cspan_d = (cx[BOX_W-1] ? -cx : cx) + (dx[BOX_W-1] ? -dx : dx);
  end

  always_ff @(posedge clk_i) begin
    rmin_q  <= rmin_d;
    cmin_q  <= cmin_d;
    rspan_q <= rspan_d;
    cspan_q <= cspan_d;
  end

  always_comb begin
    rceil   = (rspan_q + BOX_W'(2 ** FRAC_W - 1)) >> FRAC_W;
    cceil   = (cspan_q + BOX_W'(2 ** FRAC_W - 1)) >> FRAC_W;
    orows_d = (rceil > BOX_W'(DIM_SAT)) ? DIM_W'(DIM_SAT) : DIM_W'(rceil);
    ocols_d = (cceil > BOX_W'(DIM_SAT)) ? DIM_W'(DIM_SAT) : DIM_W'(cceil);
  end

  always_ff @(posedge clk_i) begin
    orows_q <= orows_d;
    ocols_q <= ocols_d;
  end

  always_comb begin
    geom_o.cos_v    = cos_q;
    geom_o.sin_v    = sin_q;
    geom_o.rows     = rows_q;
    geom_o.cols     = cols_q;
    geom_o.rmin     = rmin_q;
    geom_o.cmin     = cmin_q;
    geom_o.out_rows = orows_q;
    geom_o.out_cols = ocols_q;
    geom_o.busy     = (cnt_q != '0);
  end

endmodule

// ===== sv/irot_map.sv =====
// Four-stage address pipeline: offset, back-map products, ceiling, range check.
// Depends on irot_pkg; emits one frame store access per request as irot_mreq_t.

module irot_map import irot_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  irot_geom_t        geom_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  irot_op_e          op_i,
  input  logic [ROWS_W-1:0] row_i,
  input  logic [ROWS_W-1:0] col_i,
  input  logic [PIX_W-1:0]  pix_i,
  input  logic              mem_ready_i,
  output logic              mem_valid_o,
  output irot_mreq_t        mreq_o
);

  localparam logic signed [SUM_W-1:0] CEIL_BIAS = SUM_W'(2 ** (2 * FRAC_W) - 1);

  logic v1_q, v2_q, v3_q, v4_q;
  logic rdy1, rdy2, rdy3, rdy4, acc;

  irot_ctl_t ctl1_d, ctl1_q, ctl2_q, ctl3_q;
  irot_mreq_t mreq_d, mreq_q;

  logic signed [ANG_W-1:0]  cs, sn;
  logic signed [PT_W-1:0]   pr_d, pc_d, pr_q, pc_q;
  logic signed [MUL_W-1:0]  pr_cos_q, pc_sin_q, pr_sin_q, pc_cos_q;
  logic signed [SUM_W-1:0]  sum_r, sum_c;
  logic signed [COORD_W-1:0] sr_q, sc_q;
  logic [COORD_W-2:0]       sr_u, sc_u;
  logic                     in_src;
  logic [ADDR_W-1:0]        raddr;

  assign rdy4 = !v4_q || mem_ready_i;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign in_ready_o = rdy1 && !geom_i.busy;
  assign acc = in_valid_i && in_ready_o;

  assign cs = geom_i.cos_v;
  assign sn = geom_i.sin_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= acc;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
    end
  end

  // Stage 1: shift the output point into the box and form the write address.
  always_comb begin
    pr_d = $signed(PT_W'({row_i, {FRAC_W{1'b0}}})) + PT_W'(geom_i.rmin);
    pc_d = $signed(PT_W'({col_i, {FRAC_W{1'b0}}})) + PT_W'(geom_i.cmin);
    ctl1_d.rd    = (op_i == OP_READ);
    ctl1_d.we    = (op_i == OP_WRITE) && (int'(row_i) < MAX_ROWS) &&
                   (int'(col_i) < MAX_COLS);
    ctl1_d.waddr = ADDR_W'(ADDR_W'(row_i) * COL_STRIDE + ADDR_W'(col_i));
    ctl1_d.wdata = pix_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      pr_q   <= pr_d;
      pc_q   <= pc_d;
      ctl1_q <= ctl1_d;
    end
  end

  // Stage 2: inverse rotation products.
  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      pr_cos_q <= pr_q * cs;
      pc_sin_q <= pc_q * sn;
      pr_sin_q <= pr_q * sn;
      pc_cos_q <= pc_q * cs;
      ctl2_q   <= ctl1_q;
    end
  end

  // Stage 3: combine and round up to whole source coordinates.
  assign sum_r = SUM_W'(pr_cos_q) - SUM_W'(pc_sin_q) + CEIL_BIAS;
  assign sum_c = SUM_W'(pr_sin_q) + SUM_W'(pc_cos_q) + CEIL_BIAS;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      sr_q   <= COORD_W'(sum_r >>> (2 * FRAC_W));
      sc_q   <= COORD_W'(sum_c >>> (2 * FRAC_W));
      ctl3_q <= ctl2_q;
    end
  end

  // Stage 4: range check against source size and store bounds.
  assign sr_u = sr_q[COORD_W-2:0];
  assign sc_u = sc_q[COORD_W-2:0];

  always_comb begin
    in_src = !sr_q[COORD_W-1] && !sc_q[COORD_W-1] &&
             (sr_u < (COORD_W - 1)'(geom_i.rows)) &&
             (sc_u < (COORD_W - 1)'(geom_i.cols)) &&
             (sr_u < (COORD_W - 1)'(MAX_ROWS)) &&
             (sc_u < (COORD_W - 1)'(MAX_COLS));
    raddr = ADDR_W'(ADDR_W'(sr_u) * COL_STRIDE + ADDR_W'(sc_u));
    mreq_d.rd     = ctl3_q.rd;
    mreq_d.we     = ctl3_q.we;
    mreq_d.in_src = ctl3_q.rd && in_src;
    mreq_d.addr   = ctl3_q.rd ? raddr : ctl3_q.waddr;
    mreq_d.wdata  = ctl3_q.wdata;
  end

  always_ff @(posedge clk_i) begin
    if (rdy4) begin
      mreq_q <= mreq_d;
    end
  end

  assign mem_valid_o = v4_q;
  assign mreq_o      = mreq_q;

endmodule

// ===== sv/image_rotate_inverse_map_unit.sv =====
// Top level of the image rotate inverse map block: frame store and result stage.
// Depends on irot_pkg, irot_in_if, irot_out_if, irot_ram, irot_box and irot_map.
//
// Requests arrive on req_i (valid/ready). A write request stores one RGB source
// pixel and gives no result; a read request names an output pixel of the rotated
// image and gives exactly one result on res_o: the source pixel at the rounded-up
// back-mapped coordinates or white outside, the inside flag and the output image size.
// Throughput is one request per cycle unless a stalled result or a box recompute
// holds req_i.ready low. A read result passes four address stages (box offset,
// 28x16 multipliers, rounding add, range check) and the registered frame store read.
// Requests are processed in order, so a read always sees every earlier write.
// cfg_we_i writes one register per cycle; the user must write only while the block
// is idle, which the block itself does not enforce. req_i.ready then stays low
// while the box bounds are recomputed. Reset loads the default registers and holds
// req_i.ready low in the same way; the frame store is not cleared.
// When res_o.ready is low the result holds and the pipeline stages fill behind
// it; req_i.ready drops once every stage holds a request.

module image_rotate_inverse_map_unit import irot_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  irot_in_if.sink              req_i,
  irot_out_if.source           res_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  irot_geom_t geom;
  irot_mreq_t mreq;
  logic       mem_valid;
  logic       rdy5;
  logic       ram_we;
  logic [PIX_W-1:0] ram_rdata;
  logic       v5_q, in5_q;

  irot_box u_box (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .geom_o     (geom)
  );

  irot_map u_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .geom_i      (geom),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .op_i        (req_i.operation),
    .row_i       (req_i.row),
    .col_i       (req_i.col),
    .pix_i       ({req_i.red_in, req_i.green_in, req_i.blue_in}),
    .mem_ready_i (rdy5),
    .mem_valid_o (mem_valid),
    .mreq_o      (mreq)
  );

  assign rdy5   = !v5_q || res_o.ready;
  assign ram_we = rdy5 && mem_valid && mreq.we;

  irot_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (mreq.addr),
    .wdata_i (mreq.wdata),
    .re_i    (rdy5),
    .raddr_i (mreq.addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (rdy5) begin
      v5_q <= mem_valid && mreq.rd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy5) begin
      in5_q <= mreq.in_src;
    end
  end

  assign res_o.valid      = v5_q;
  assign res_o.red_out    = in5_q ? ram_rdata[PIX_W-1 -: CH_W] : WHITE;
  assign res_o.green_out  = in5_q ? ram_rdata[2*CH_W-1 -: CH_W] : WHITE;
  assign res_o.blue_out   = in5_q ? ram_rdata[CH_W-1:0] : WHITE;
  assign res_o.inside_res = in5_q;
  assign res_o.out_rows   = geom.out_rows;
  assign res_o.out_cols   = geom.out_cols;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("request taken right after a configuration write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v5_q && in5_q && !res_o.ready) |=> $stable(ram_rdata))
    else $error("frame store read data changed under a stalled result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> !v5_q)
    else $error("pixel write produced a result");
`endif

endmodule

// ===== bench/testbench.sv =====
// Self-checking bench for image_rotate_inverse_map_unit: a directed list, then random phases.
// Depends on irot_pkg and the irot_in_if / irot_out_if interfaces; predicts every read result.

module testbench;
  import irot_pkg::*;

  localparam int PHASES          = 10;
  localparam int ITEMS_PER_PHASE = 200;
  localparam int IDLE_PCT        = 24;
  localparam int HOLD_CYCLES     = 80;
  localparam int SETTLE_CYCLES   = 10;
  localparam int WATCHDOG_LIMIT  = 4000;
  localparam int REPORT_LIMIT    = 10;
  localparam int ANGLES          = 9;

  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic             in_src;
    logic [DIM_W-1:0] rows;
    logic [DIM_W-1:0] cols;
  } pixel_res_t;

  typedef enum bit {STEP_REQ, STEP_REG} step_kind_e;

  typedef struct packed {
    step_kind_e        kind;
    irot_cfg_e         reg_idx;
    logic [CFG_W-1:0]  reg_val;
    irot_op_e          op;
    logic [ROWS_W-1:0] row;
    logic [ROWS_W-1:0] col;
    logic [PIX_W-1:0]  color;
    bit                typed;
    pixel_res_t        want;
  } plan_step_t;

  localparam pixel_res_t NO_WANT = '0;
  localparam int DIRECTED_LEN = 29;

  localparam plan_step_t DIRECTED [DIRECTED_LEN] = '{
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_WRITE, 9'd0, 9'd0, 24'h0C2238, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd0, 9'd0, 24'h0, 1'b1,
      {24'h0C2238, 1'b1, 10'd255, 10'd255}},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_WRITE, 9'd256, 9'd0, 24'hFFFFFF, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_WRITE, 9'd0, 9'd256, 24'h010101, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_WRITE, 9'd511, 9'd511, 24'hAAAAAA, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd0, 9'd0, 24'h0, 1'b1,
      {24'h0C2238, 1'b1, 10'd255, 10'd255}},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_WRITE, 9'd255, 9'd255, 24'hFF00FF, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd255, 9'd255, 24'h0, 1'b1,
      {24'hFF00FF, 1'b1, 10'd255, 10'd255}},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd511, 9'd511, 24'h0, 1'b1,
      {24'hFFFFFF, 1'b0, 10'd255, 10'd255}},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_WRITE, 9'd17, 9'd200, 24'h00FF00, 1'b0, NO_WANT},
    '{STEP_REG, CFG_COS, 16'h0000, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_SIN, 16'h4000, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd200, 9'd238, 24'h0, 1'b1,
      {24'h00FF00, 1'b1, 10'd255, 10'd255}},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd0, 9'd255, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_ROWS, 16'd0, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd511, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_ROWS, 16'd400, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_COS, 16'h4000, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_SIN, 16'h0000, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd300, 9'd0, 24'h0, 1'b1,
      {24'hFFFFFF, 1'b0, 10'd399, 10'd255}},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd0, 9'd0, 24'h0, 1'b1,
      {24'h0C2238, 1'b1, 10'd399, 10'd255}},
    '{STEP_REG, CFG_ROWS, 16'd511, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_COLS, 16'd511, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_COS, 16'h8000, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REG, CFG_SIN, 16'h7FFF, OP_WRITE, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd0, 9'd0, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd511, 9'd511, 24'h0, 1'b0, NO_WANT},
    '{STEP_REQ, CFG_ROWS, 16'd0, OP_READ, 9'd100, 9'd300, 24'h0, 1'b0, NO_WANT}
  };

  localparam logic signed [ANG_W-1:0] ANGLE_COS [ANGLES] = '{
    16'sd16384, 16'sd0, -16'sd16384, 16'sd0, 16'sd11585, 16'sd11585, 16'sd14189,
    -16'sd8192, 16'sd15137
  };
  localparam logic signed [ANG_W-1:0] ANGLE_SIN [ANGLES] = '{
    16'sd0, 16'sd16384, 16'sd0, -16'sd16384, 16'sd11585, -16'sd11585, 16'sd8192,
    16'sd14189, -16'sd6270
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0]     cfg_data_i;

  irot_in_if  req_if ();
  irot_out_if res_if ();

  image_rotate_inverse_map_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .res_o      (res_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  logic [PIX_W-1:0]          frame_store   [MEM_DEPTH];
  bit                        frame_written [MEM_DEPTH];
  logic [ROWS_W-1:0]         geo_rows = ROWS_RST;
  logic [ROWS_W-1:0]         geo_cols = COLS_RST;
  logic signed [ANG_W-1:0]   geo_cos  = COS_RST;
  logic signed [ANG_W-1:0]   geo_sin  = SIN_RST;

  pixel_res_t pending_pixels [$];
  int         mismatches    = 0;
  int         src_idle_pct  = IDLE_PCT;
  int         snk_idle_pct  = IDLE_PCT;
  bit         hold_off_req  = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint ceil_div(input longint v, input longint d);
    if (v >= 0) return (v + d - 1) / d;
    return v / d;
  endfunction

  function automatic logic [DIM_W-1:0] sat_dim(input longint v);
    if (v < 0) return '0;
    if (v > DIM_SAT) return DIM_W'(DIM_SAT);
    return DIM_W'(v);
  endfunction

  function automatic void map_back(input logic [ROWS_W-1:0] row, input logic [ROWS_W-1:0] col,
                                   output pixel_res_t res, output bit hit,
                                   output int unsigned addr);
    longint one, cs, sn, nr, nc, rr, rc, rmin, rmax, cmin, cmax, pr, pc, sr, sc;
    longint cr [4];
    longint cc [4];
    one  = longint'(1) << FRAC_W;
    cs   = geo_cos;
    sn   = geo_sin;
    nr   = longint'(geo_rows);
    nc   = longint'(geo_cols);
    cr   = '{0, 0, nr - 1, nr - 1};
    cc   = '{0, nc - 1, 0, nc - 1};
    rmin = 0;
    rmax = 0;
    cmin = 0;
    cmax = 0;
    for (int k = 0; k < 4; k++) begin
      rr = cr[k] * cs + cc[k] * sn;
      rc = -cr[k] * sn + cc[k] * cs;
      if (rr < rmin) rmin = rr;
      if (rr > rmax) rmax = rr;
      if (rc < cmin) cmin = rc;
      if (rc > cmax) cmax = rc;
    end
    pr   = (longint'(row) << FRAC_W) + rmin;
    pc   = (longint'(col) << FRAC_W) + cmin;
    sr   = ceil_div(pr * cs - pc * sn, one * one);
    sc   = ceil_div(pr * sn + pc * cs, one * one);
    hit  = sr >= 0 && sr < nr && sc >= 0 && sc < nc && sr < MAX_ROWS && sc < MAX_COLS;
    addr = hit ? 32'(sr * MAX_COLS + sc) : 0;
    {res.red, res.green, res.blue} = hit ? frame_store[addr] : {WHITE, WHITE, WHITE};
    res.in_src = hit;
    res.rows   = sat_dim(ceil_div(rmax - rmin, one));
    res.cols   = sat_dim(ceil_div(cmax - cmin, one));
  endfunction

  function automatic void note_mismatch(input bit orphan, input pixel_res_t want,
                                        input pixel_res_t got);
    mismatches++;
    if (mismatches > REPORT_LIMIT) return;
    if (orphan)
      $display("[%0t] result with no request waiting: rgb=%h in=%0b rows=%0d cols=%0d",
               $realtime, {got.red, got.green, got.blue}, got.in_src, got.rows, got.cols);
    else
      $display("[%0t] mismatch: want rgb=%h in=%0b rows=%0d cols=%0d, got rgb=%h in=%0b rows=%0d cols=%0d",
               $realtime, {want.red, want.green, want.blue}, want.in_src, want.rows, want.cols,
               {got.red, got.green, got.blue}, got.in_src, got.rows, got.cols);
  endfunction

  task automatic offer_request(input irot_op_e op, input logic [ROWS_W-1:0] row,
                               input logic [ROWS_W-1:0] col, input logic [PIX_W-1:0] color,
                               input bit typed, input pixel_res_t want);
    pixel_res_t  mapped;
    bit          hit;
    int unsigned addr;
    if ($urandom_range(99) < src_idle_pct) begin
      req_if.valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    req_if.valid     <= 1'b1;
    req_if.operation <= op;
    req_if.row       <= row;
    req_if.col       <= col;
    req_if.red_in    <= color[23:16];
    req_if.green_in  <= color[15:8];
    req_if.blue_in   <= color[7:0];
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    if (op == OP_WRITE) begin
      if (row < MAX_ROWS && col < MAX_COLS) begin
        frame_store[int'(row) * MAX_COLS + int'(col)]   = color;
        frame_written[int'(row) * MAX_COLS + int'(col)] = 1'b1;
      end
    end else begin
      map_back(row, col, mapped, hit, addr);
      pending_pixels.push_back(typed ? want : mapped);
    end
  endtask

  // Load the source pixel a read lands on first, if it was never written.
  task automatic issue_item(input irot_op_e op, input logic [ROWS_W-1:0] row,
                            input logic [ROWS_W-1:0] col, input logic [PIX_W-1:0] color,
                            input bit typed, input pixel_res_t want);
    pixel_res_t  mapped;
    bit          hit;
    int unsigned addr;
    if (op == OP_READ) begin
      map_back(row, col, mapped, hit, addr);
      if (hit && !frame_written[addr])
        offer_request(OP_WRITE, ROWS_W'(addr / MAX_COLS), ROWS_W'(addr % MAX_COLS),
                      PIX_W'($urandom), 1'b0, NO_WANT);
    end
    offer_request(op, row, col, color, typed, want);
  endtask

  task automatic drain_block();
    req_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input irot_cfg_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_ROWS: geo_rows = val[ROWS_W-1:0];
      CFG_COLS: geo_cols = val[ROWS_W-1:0];
      CFG_COS:  geo_cos  = val[ANG_W-1:0];
      CFG_SIN:  geo_sin  = val[ANG_W-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic int pick_extent();
    case ($urandom_range(9))
      6:       return MAX_ROWS;
      7:       return 1;
      8:       return 0;
      9:       return $urandom_range(0, 511);
      default: return $urandom_range(1, 20);
    endcase
  endfunction

  initial begin
    pixel_res_t        dims;
    bit                hit;
    int unsigned       addr;
    bit                last_was_reg;
    int                new_rows, new_cols, ang, served, pick, src_r, src_c;
    logic [ROWS_W-1:0] row, col;
    logic [ANG_W-1:0]  new_cos, new_sin;
    rst_ni           <= 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= CFG_ROWS;
    cfg_data_i       <= '0;
    req_if.valid     <= 1'b0;
    req_if.operation <= OP_WRITE;
    req_if.row       <= '0;
    req_if.col       <= '0;
    req_if.red_in    <= '0;
    req_if.green_in  <= '0;
    req_if.blue_in   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    last_was_reg = 1'b0;
    for (int i = 0; i < DIRECTED_LEN; i++) begin
      if (DIRECTED[i].kind == STEP_REG) begin
        if (!last_was_reg) drain_block();
        write_reg(DIRECTED[i].reg_idx, DIRECTED[i].reg_val);
        last_was_reg = 1'b1;
      end else begin
        issue_item(DIRECTED[i].op, DIRECTED[i].row, DIRECTED[i].col, DIRECTED[i].color,
                   DIRECTED[i].typed, DIRECTED[i].want);
        last_was_reg = 1'b0;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      new_rows = (p == 0) ? 1 : (p == 1) ? MAX_ROWS : pick_extent();
      new_cols = (p == 0) ? MAX_COLS : (p == 1) ? 1 : pick_extent();
      if ($urandom_range(4) == 0) begin
        new_cos = ANG_W'($urandom);
        new_sin = ANG_W'($urandom);
      end else begin
        ang     = $urandom_range(0, ANGLES - 1);
        new_cos = ANGLE_COS[ang];
        new_sin = ANGLE_SIN[ang];
      end
      drain_block();
      write_reg(CFG_ROWS, CFG_W'(new_rows));
      write_reg(CFG_COLS, CFG_W'(new_cols));
      write_reg(CFG_COS, new_cos);
      write_reg(CFG_SIN, new_sin);
      src_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      snk_idle_pct = (p == 3) ? 0 : IDLE_PCT;
      if (p == 1 || p == 6) hold_off_req = 1'b1;
      map_back('0, '0, dims, hit, addr);
      src_r  = (geo_rows == 0 || geo_rows > MAX_ROWS) ? MAX_ROWS : int'(geo_rows);
      src_c  = (geo_cols == 0 || geo_cols > MAX_COLS) ? MAX_COLS : int'(geo_cols);
      served = 0;
      while (served < ITEMS_PER_PHASE) begin
        pick = $urandom_range(99);
        if (pick < 45) begin
          row = ROWS_W'($urandom_range(0, dims.rows > 511 ? 511 : int'(dims.rows)));
          col = ROWS_W'($urandom_range(0, dims.cols > 511 ? 511 : int'(dims.cols)));
          issue_item(OP_READ, row, col, PIX_W'($urandom), 1'b0, NO_WANT);
          served++;
        end else if (pick < 75) begin
          row = ROWS_W'($urandom_range(0, src_r - 1));
          col = ROWS_W'($urandom_range(0, src_c - 1));
          issue_item(OP_WRITE, row, col, PIX_W'($urandom), 1'b0, NO_WANT);
          served++;
        end else if (pick < 85) begin
          row = ROWS_W'($urandom);
          col = ROWS_W'($urandom);
          issue_item(OP_READ, row, col, PIX_W'($urandom), 1'b0, NO_WANT);
          served++;
        end else begin
          row = ROWS_W'($urandom);
          col = ROWS_W'($urandom);
          issue_item(OP_WRITE, row, col, PIX_W'($urandom), 1'b0, NO_WANT);
          if (row < MAX_ROWS && col < MAX_COLS) served++;
        end
      end
    end

    drain_block();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    pixel_res_t got;
    pixel_res_t want;
    int         hold_left;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (res_if.valid && res_if.ready) begin
        got = {res_if.red_out, res_if.green_out, res_if.blue_out, res_if.inside_res,
               res_if.out_rows, res_if.out_cols};
        if (pending_pixels.size() == 0) begin
          note_mismatch(1'b1, NO_WANT, got);
        end else begin
          want = pending_pixels.pop_front();
          if (got !== want) note_mismatch(1'b0, want, got);
        end
      end
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left    = hold_left - 1;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet = quiet + 1;
        if (quiet >= WATCHDOG_LIMIT) begin
          $display("DONE: errors detected");
          $finish;
        end
      end
    end
  end

endmodule
